[hw/rtl/hktsp_pkg.sv]
// Shared types and constants for the bitmask tour solver.
package hktsp_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_SOLVE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int CITY_W = 4;
  localparam int LEN_W  = 20;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CLEAR  = 9'b000000010,
    ST_INIT   = 9'b000000100,
    ST_RDCUR  = 9'b000001000,
    ST_RDSUB  = 9'b000010000,
    ST_UPDATE = 9'b000100000,
    ST_ROOT   = 9'b001000000,
    ST_WALK   = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

endpackage

[hw/rtl/held_karp_tsp_solver.sv]
// Top level of the bitmask tour solver: edge store, cost table and sequencer.
// Clear sweeps every edge slot and an edge write stores one edge; neither gives a result.
// Solve opens each set and city in turn; for each successor it then does a table read
// and a compare-and-update step.
// The tour then leaves one result per table read and emit step; the receiver cannot stall.
// Synchronous active-low reset: node_count 1, edge store swept absent, then the sequencer idles.
module held_karp_tsp_solver
  import hktsp_pkg::*;
#(
  parameter int MAX_NODES   = 12,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_command,
  input  logic [3:0]          in_from_city,
  input  logic [3:0]          in_to_city,
  input  logic [15:0]         in_edge_weight,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  output logic                out_strobe,
  output logic [CITY_W-1:0]   out_city,
  output logic [LEN_W-1:0]    out_tour_length,
  output logic                out_found,
  output logic                out_last
);

  localparam int EDGES  = MAX_NODES * MAX_NODES;
  localparam int EA_W   = $clog2(EDGES);
  localparam int CI_W   = $clog2(MAX_NODES);
  localparam int DEPTH  = (1 << MAX_NODES) * MAX_NODES;
  localparam int TA_W   = $clog2(DEPTH);
  localparam int COST_W = WEIGHT_BITS + CI_W + 1;

  logic [WEIGHT_BITS:0] edge_mem [EDGES];
  logic [COST_W+CI_W:0] tab_mem  [DEPTH];

  state_t               state_r, state_nxt;
  logic [3:0]           ncfg_r;
  logic [EA_W-1:0]      clr_r;
  logic [MAX_NODES-1:0] s_r, full_r, set_r;
  logic [CI_W-1:0]      u_r, v_r, n_m1_r, at_r;
  logic [CI_W:0]        walk_r;
  logic [COST_W:0]      cur_r, root_r;
  logic [CI_W-1:0]      best_r;
  logic [WEIGHT_BITS:0] edge_q;
  logic [COST_W+CI_W:0] tab_q;
  logic [COST_W:0]      cost_q;
  logic [CI_W-1:0]      nxt_q;

  logic                 e_we, t_we, t_re;
  logic [EA_W-1:0]      e_addr;
  logic [WEIGHT_BITS:0] e_wd;
  logic [TA_W-1:0]      t_addr;
  logic [COST_W:0]      t_wcost;
  logic [CI_W-1:0]      t_wnxt;

  logic                 accept;
  logic [CI_W-1:0]      n_m1;
  logic                 u_ok;
  logic [MAX_NODES-1:0] sub_set, walk_set;
  logic                 sub_full, sub_reach, upd, walk_done;
  logic [COST_W-1:0]    sub_cost;
  logic [COST_W:0]      cand;

  function automatic logic [TA_W-1:0] slot(logic [MAX_NODES-1:0] s, logic [CI_W-1:0] c);
    slot = TA_W'(s * MAX_NODES) + TA_W'(c);
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    if (ncfg_r == 4'd0) n_m1 = '0;
    else if (32'(ncfg_r) > MAX_NODES) n_m1 = CI_W'(MAX_NODES - 1);
    else n_m1 = CI_W'(ncfg_r - 4'd1);
  end

  assign cost_q = tab_q[COST_W+CI_W:CI_W];
  assign nxt_q  = tab_q[CI_W-1:0];

  assign u_ok      = (u_r == '0) || s_r[u_r];
  assign sub_set   = s_r | (MAX_NODES'(1) << v_r);
  assign sub_full  = (sub_set == full_r);
  // full set: only the entry at city 0 is reachable, with cost zero
  assign sub_reach = sub_full ? (v_r == '0) : cost_q[COST_W];
  assign sub_cost  = sub_full ? '0 : cost_q[COST_W-1:0];
  assign cand      = {1'b1, sub_cost + COST_W'(edge_q[WEIGHT_BITS-1:0])};
  assign upd       = edge_q[WEIGHT_BITS] && !s_r[v_r] && sub_reach &&
                     (!cur_r[COST_W] || cand[COST_W-1:0] < cur_r[COST_W-1:0]);

  assign walk_set  = set_r | (MAX_NODES'(1) << nxt_q);
  assign walk_done = (walk_set == full_r) || (walk_r == {1'b0, n_m1_r} + 1'b1);

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_addr] <= e_wd;
    edge_q <= edge_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tab_mem[t_addr] <= {t_wcost, t_wnxt};
    end else if (t_re) begin
      tab_q <= tab_mem[t_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    e_we = 1'b0; e_addr = EA_W'(u_r * MAX_NODES) + EA_W'(v_r); e_wd = '0;
    t_we = 1'b0; t_re = 1'b0; t_addr = slot(s_r, u_r);
    t_wcost = '0; t_wnxt = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_EDGE: begin
              if (32'(in_from_city) < MAX_NODES && 32'(in_to_city) < MAX_NODES) begin
                e_we   = 1'b1;
                e_addr = EA_W'(32'(in_from_city) * MAX_NODES + 32'(in_to_city));
                e_wd   = {1'b1, WEIGHT_BITS'(in_edge_weight)};
              end
            end
            CMD_SOLVE: state_nxt = ST_INIT;
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        e_we = 1'b1; e_addr = clr_r;
        if (32'(clr_r) == EDGES - 1) state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        state_nxt = ST_RDCUR;
      end
      ST_RDCUR: begin
        if (!u_ok) begin
          if (u_r == n_m1_r && s_r == '0) state_nxt = ST_ROOT;
        end else begin
          t_we = 1'b1; t_wcost = '0;
          state_nxt = ST_RDSUB;
        end
      end
      ST_RDSUB: begin
        t_re = 1'b1; t_addr = slot(sub_set, v_r);
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (v_r == n_m1_r) begin
          t_we = 1'b1;
          t_wcost = upd ? cand : cur_r;
          t_wnxt  = upd ? v_r : best_r;
          if (u_r == n_m1_r && s_r == '0) state_nxt = ST_ROOT;
          else state_nxt = ST_RDCUR;
        end else state_nxt = ST_RDSUB;
      end
      ST_ROOT: begin
        t_re = 1'b1; t_addr = slot('0, '0);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        t_re = 1'b1; t_addr = slot(set_r, at_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!root_r[COST_W] || (walk_r != '0 && walk_done)) state_nxt = ST_IDLE;
        else state_nxt = ST_WALK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ncfg_r  <= 4'd1;
      clr_r   <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_we) ncfg_r <= cfg_wdata;
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          clr_r <= '0;
          if (accept && in_command == CMD_SOLVE) begin
            n_m1_r <= n_m1;
            full_r <= MAX_NODES'((MAX_NODES'(1) << n_m1) << 1) - MAX_NODES'(1);
          end
        end
        ST_CLEAR: clr_r <= clr_r + EA_W'(1);
        ST_INIT: begin
          s_r <= full_r - MAX_NODES'(1);
          u_r <= '0;
          v_r <= '0;
          cur_r <= '0;
          best_r <= '0;
        end
        ST_RDCUR: begin
          v_r <= '0; cur_r <= '0; best_r <= '0;
          if (!u_ok) begin
            if (u_r == n_m1_r) begin
              u_r <= '0;
              if (s_r != '0) s_r <= s_r - MAX_NODES'(1);
            end else u_r <= u_r + CI_W'(1);
          end
        end
        ST_UPDATE: begin
          if (upd) begin
            cur_r <= cand; best_r <= v_r;
          end
          if (v_r == n_m1_r) begin
            v_r <= '0;
            if (u_r == n_m1_r) begin
              u_r <= '0;
              if (s_r != '0) s_r <= s_r - MAX_NODES'(1);
            end else u_r <= u_r + CI_W'(1);
          end else v_r <= v_r + CI_W'(1);
        end
        ST_ROOT: begin
          set_r <= '0; at_r <= '0; walk_r <= '0;
        end
        ST_WALK: begin
          if (walk_r == '0) root_r <= cost_q;
        end
        ST_EMIT: begin
          out_strobe <= 1'b1;
          out_tour_length <= LEN_W'(root_r[COST_W-1:0]);
          out_found <= root_r[COST_W];
          if (!root_r[COST_W]) begin
            out_city <= '0; out_last <= 1'b1;
          end else if (walk_r == '0) begin
            out_city <= '0; out_last <= 1'b0; walk_r <= walk_r + 1'b1;
          end else begin
            out_city <= CITY_W'(nxt_q);
            set_r <= walk_set;
            at_r <= nxt_q;
            walk_r <= walk_r + 1'b1;
            out_last <= walk_done;
          end
        end
        default: ;
      endcase
    end
  end

  property p_idle_quiet;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_IDLE) |=> !out_strobe || $past(state_r) != ST_IDLE;
  endproperty
  a_idle_quiet: assert property (p_idle_quiet) else $error("result out of idle");

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != ST_IDLE)) else $error("busy mismatch");

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last && out_strobe |=> !out_strobe) else $error("result after last");

endmodule

[sim/held_karp_tsp_solver_chk.sv]
// Checker for the tour solver: predicts tours from observed requests and compares results.
module held_karp_tsp_solver_chk
  import hktsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_from_city,
  input  logic [3:0]  in_to_city,
  input  logic [15:0] in_edge_weight,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        out_strobe,
  input  logic [3:0]  out_city,
  input  logic [19:0] out_tour_length,
  input  logic        out_found,
  input  logic        out_last,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NC = 12;

  typedef struct packed {
    logic [3:0]  city;
    logic [19:0] len;
    logic        found;
    logic        last;
  } stop_t;

  stop_t       tour_q[$];
  logic        edge_on[NC*NC];
  logic [15:0] edge_w[NC*NC];
  logic [3:0]  cities_reg;
  bit          reach[4096*NC];
  longint      cost[4096*NC];
  logic [3:0]  succ[4096*NC];

  function automatic void clear_edges();
    for (int i = 0; i < NC*NC; i++) begin
      edge_on[i] = 1'b0;
      edge_w[i] = '0;
    end
  endfunction

  function automatic void predict_tour();
    int n, full, s, at, k, nx, vis, idx, sub;
    longint cand, len;
    stop_t r;
    n = (cities_reg == 0) ? 1 : (cities_reg > NC) ? NC : cities_reg;
    full = (1 << n) - 1;
    for (s = 0; s <= full; s++)
      for (int u = 0; u < n; u++) begin
        reach[s*NC+u] = 0;
        cost[s*NC+u] = 0;
        succ[s*NC+u] = 0;
      end
    reach[full*NC] = 1;
    for (s = full - 1; s >= 0; s--)
      for (int u = 0; u < n; u++) begin
        if (u != 0 && !s[u]) continue;
        idx = s*NC + u;
        for (int v = 0; v < n; v++) begin
          if (!edge_on[u*NC+v] || s[v]) continue;
          sub = (s | (1 << v))*NC + v;
          if (!reach[sub]) continue;
          cand = cost[sub] + edge_w[u*NC+v];
          if (!reach[idx] || cand < cost[idx]) begin
            reach[idx] = 1;
            cost[idx] = cand;
            succ[idx] = 4'(v);
          end
        end
      end
    if (!reach[0]) begin
      r = '{city: 4'd0, len: 20'd0, found: 1'b0, last: 1'b1};
      tour_q.push_back(r);
      return;
    end
    len = cost[0];
    r = '{city: 4'd0, len: len[19:0], found: 1'b1, last: 1'b0};
    tour_q.push_back(r);
    vis = 0;
    at = 0;
    for (k = 0; k < n && vis != full; k++) begin
      nx = succ[vis*NC+at];
      vis = vis | (1 << nx);
      at = nx;
      r = '{city: nx[3:0], len: len[19:0], found: 1'b1, last: 1'b0};
      tour_q.push_back(r);
    end
    tour_q[tour_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    stop_t exp_r;
    if (!rst_n) begin
      clear_edges();
      tour_q.delete();
      cities_reg <= 4'd1;
      fails <= 0;
    end else begin
      if (cfg_we) cities_reg <= cfg_wdata;
      if (start && !busy) begin
        case (in_command)
          CMD_CLEAR: clear_edges();
          CMD_EDGE: if (in_from_city < NC && in_to_city < NC) begin
            edge_on[in_from_city*NC+in_to_city] = 1'b1;
            edge_w[in_from_city*NC+in_to_city] = in_edge_weight;
          end
          CMD_SOLVE: predict_tour();
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (tour_q.size() == 0) begin
          $display("%0t: unexpected result city=%0d len=%0d found=%0d last=%0d", $time,
                   out_city, out_tour_length, out_found, out_last);
          fails <= fails + 1;
        end else begin
          exp_r = tour_q.pop_front();
          if (exp_r.city !== out_city || exp_r.len !== out_tour_length ||
              exp_r.found !== out_found || exp_r.last !== out_last) begin
            $display("%0t: mismatch expected city=%0d len=%0d found=%0d last=%0d", $time,
                     exp_r.city, exp_r.len, exp_r.found, exp_r.last);
            $display("%0t:          actual   city=%0d len=%0d found=%0d last=%0d", $time,
                     out_city, out_tour_length, out_found, out_last);
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= tour_q.size();
  end
endmodule

[sim/held_karp_tsp_solver_tb.sv]
// Testbench top for the tour solver: reset, clock, request stimulus and verdict.
module held_karp_tsp_solver_tb;
  import hktsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_CLEAR;
  logic [3:0]  in_from_city = '0;
  logic [3:0]  in_to_city = '0;
  logic [15:0] in_edge_weight = '0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        out_strobe;
  logic [3:0]  out_city;
  logic [19:0] out_tour_length;
  logic        out_found;
  logic        out_last;
  int          fails;
  int          pending;
  int          solves = 0;
  int          requests = 0;
  int          burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  held_karp_tsp_solver u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_from_city(in_from_city), .in_to_city(in_to_city),
    .in_edge_weight(in_edge_weight), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_city(out_city), .out_tour_length(out_tour_length),
    .out_found(out_found), .out_last(out_last)
  );

  held_karp_tsp_solver_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_from_city(in_from_city), .in_to_city(in_to_city),
    .in_edge_weight(in_edge_weight), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_city(out_city), .out_tour_length(out_tour_length),
    .out_found(out_found), .out_last(out_last), .fails(fails), .pending(pending)
  );

  task automatic issue(input logic [1:0] cmd, input logic [3:0] src, input logic [3:0] dst,
                       input logic [15:0] w);
    start <= 1'b1;
    in_command <= cmd;
    in_from_city <= src;
    in_to_city <= dst;
    in_edge_weight <= w;
    do @(posedge clk); while (busy);
    requests++;
    if (cmd == CMD_SOLVE) solves++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic set_cities(input logic [3:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
    issue(CMD_EDGE, 4'd0, 4'd0, 16'h0000);
    issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
    set_cities(4'd0);
    issue(CMD_EDGE, 4'd0, 4'd0, 16'hffff);
    issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
    set_cities(4'd3);
    issue(CMD_EDGE, 4'd0, 4'd1, 16'd5);
    issue(CMD_EDGE, 4'd1, 4'd2, 16'd5);
    issue(CMD_EDGE, 4'd2, 4'd0, 16'd5);
    issue(CMD_EDGE, 4'd0, 4'd2, 16'd5);
    issue(CMD_EDGE, 4'd2, 4'd1, 16'd5);
    issue(CMD_EDGE, 4'd1, 4'd0, 16'd5);
    issue(CMD_EDGE, 4'd15, 4'd1, 16'd1);
    issue(CMD_EDGE, 4'd1, 4'd12, 16'd1);
    issue(CMD_EDGE, 4'd0, 4'd5, 16'd0);
    issue(CMD_UNUSED, 4'd15, 4'd15, 16'hffff);
    issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
    issue(CMD_CLEAR, 4'd0, 4'd0, 16'd0);
    issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
    set_cities(4'd15);
    for (int c = 0; c < 12; c++) issue(CMD_EDGE, 4'(c), 4'((c + 1) % 12), 16'hffff);
    issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);

    for (int ph = 0; ph < 6; ph++) begin
      n = $urandom_range(1, 5);
      if (ph == 5) n = 8;
      set_cities(4'(n));
      issue(CMD_CLEAR, 4'd0, 4'd0, 16'd0);
      for (int a = 0; a < n; a++)
        for (int b = 0; b < n; b++)
          if ($urandom_range(0, 1) != 0)
            issue(CMD_EDGE, 4'(a), 4'(b), ($urandom_range(0, 4) == 0) ?
                  16'($urandom_range(0, 3)) : 16'($urandom()));
      if ($urandom_range(0, 1))
        issue(CMD_UNUSED, 4'($urandom()), 4'($urandom()), 16'($urandom()));
      if ($urandom_range(0, 2) == 0)
        issue(CMD_EDGE, 4'($urandom_range(12, 15)), 4'($urandom()), 16'($urandom()));
      if ($urandom_range(0, 2) == 0)
        issue(CMD_EDGE, 4'($urandom_range(n, 11)), 4'($urandom_range(0, 11)), 16'($urandom()));
      issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
      if (ph == 3) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      issue(CMD_SOLVE, 4'd0, 4'd0, 16'd0);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests, %0d solves, city counts from 0 to 15.", requests, solves);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

[files.f]
hw/rtl/hktsp_pkg.sv
hw/rtl/held_karp_tsp_solver.sv
sim/held_karp_tsp_solver_chk.sv
sim/held_karp_tsp_solver_tb.sv
